// ===== hdl/bms_response_frame_receiver_core_defines.svh =====
// assertion macros shared by the frame receiver modules
// expects signals named clk and rst in the module that uses them
`ifndef BMS_RESPONSE_FRAME_RECEIVER_CORE_DEFINES_SVH
`define BMS_RESPONSE_FRAME_RECEIVER_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define BMSRX_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next
`define BMSRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bmsrx_pkg.sv =====
// types and constants for the response frame receiver
// no dependencies; used by all receiver modules
`default_nettype none

package bmsrx_pkg;

  localparam logic [3:0]  FRAME_LEN    = 4'd13;  // sync, 11 body bytes, checksum
  localparam logic [3:0]  LAST_POS     = 4'd12;  // position of the checksum byte
  localparam int          BODY_LAST    = 11;     // last stored frame byte
  localparam logic [7:0]  GOOD_ADDRESS = 8'h01;
  localparam logic [7:0]  LOUD_ADDRESS = 8'h20;
  localparam logic [7:0]  SYNC_RESET   = 8'hA5;
  localparam logic [15:0] ERR_MAX      = 16'hFFFF;
  localparam int          TDATA_W      = 112;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_ADDR_HIGH = 3'd1,
    STATUS_ADDR_LOW  = 3'd2,
    STATUS_SUM_BAD   = 3'd3,
    STATUS_SUM_ZERO  = 3'd4,
    STATUS_OVERRUN   = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] error_total;
    logic [63:0] payload;
    logic [7:0]  length_byte;
    logic [7:0]  command_echo;
    logic [7:0]  responder_address;
    logic [5:0]  frame_slot;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bmsrx_assembler.sv =====
// frame assembly: sync hunt, byte store, running sum, checks, error count
// depends on bmsrx_pkg and the assertion macro header
`default_nettype none
`include "bms_response_frame_receiver_core_defines.svh"

module bmsrx_assembler #(
  parameter int FRAME_SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [7:0]       cfg_value,
  input  wire logic             in_accept,
  input  wire logic             in_action,
  input  wire logic [7:0]       in_byte,
  output logic                  res_valid,
  output bmsrx_pkg::result_t    res
);
  import bmsrx_pkg::*;

  localparam int SLOT_W = $clog2(FRAME_SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(FRAME_SLOTS);

  logic [7:0]        sync_byte;
  logic              in_frame, in_frame_next;
  logic [3:0]        byte_pos, byte_pos_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [7:0]        run_sum, run_sum_next;
  logic [15:0]       err_count, err_count_next;
  logic [7:0]        fb [1:BODY_LAST];

  logic              slots_left;
  logic              store;
  logic              overrun;
  logic              err_inc;
  status_t           status;
  logic [6:0]        slot_wide;

  assign slots_left = (slot < SLOT_LIMIT);
  assign slot_wide  = 7'(slot);

  always_comb begin
    in_frame_next = in_frame;
    byte_pos_next = byte_pos;
    slot_next     = slot;
    run_sum_next  = run_sum;
    store         = 1'b0;
    overrun       = 1'b0;
    err_inc       = 1'b0;
    res_valid     = 1'b0;
    status        = STATUS_OK;
    if (in_accept) begin
      if (in_action) begin
        in_frame_next = 1'b0;
        byte_pos_next = '0;
        slot_next     = '0;
        run_sum_next  = '0;
      end else if (!in_frame) begin
        if (in_byte == sync_byte) begin
          in_frame_next = 1'b1;
          byte_pos_next = '0;
          run_sum_next  = '0;
          // with no slot left the frame opens empty and the next byte overruns
          if (slots_left) begin
            byte_pos_next = 4'd1;
            run_sum_next  = in_byte;
          end
        end
      end else if (!slots_left || byte_pos >= FRAME_LEN) begin
        in_frame_next = 1'b0;
        overrun       = 1'b1;
        err_inc       = 1'b1;
        res_valid     = 1'b1;
        status        = STATUS_OVERRUN;
      end else if (byte_pos < LAST_POS) begin
        store         = 1'b1;
        run_sum_next  = run_sum + in_byte;
        byte_pos_next = byte_pos + 4'd1;
      end else begin
        // checksum byte closes the frame
        res_valid = 1'b1;
        if (fb[1] != GOOD_ADDRESS) begin
          if (fb[1] >= LOUD_ADDRESS) begin
            status  = STATUS_ADDR_HIGH;
            err_inc = 1'b1;
          end else begin
            status  = STATUS_ADDR_LOW;
          end
        end else if (run_sum != in_byte) begin
          status  = STATUS_SUM_BAD;
          err_inc = 1'b1;
        end else if (run_sum == 8'd0) begin
          status  = STATUS_SUM_ZERO;
          err_inc = 1'b1;
        end
        slot_next     = slot + SLOT_W'(1);
        in_frame_next = 1'b0;
        byte_pos_next = '0;
      end
    end
  end

  assign err_count_next = (err_inc && err_count != ERR_MAX) ? err_count + 16'd1 : err_count;

  always_comb begin
    res.status            = status;
    res.error_total       = err_count_next;
    res.frame_slot        = slot_wide[5:0];
    res.responder_address = overrun ? 8'd0 : fb[1];
    res.command_echo      = overrun ? 8'd0 : fb[2];
    res.length_byte       = overrun ? 8'd0 : fb[3];
    res.payload           = overrun ? 64'd0
                          : {fb[4], fb[5], fb[6], fb[7], fb[8], fb[9], fb[10], fb[11]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
      in_frame  <= 1'b0;
      byte_pos  <= '0;
      slot      <= '0;
      run_sum   <= '0;
      err_count <= '0;
    end else begin
      if (cfg_write) begin
        sync_byte <= cfg_value;
      end
      in_frame  <= in_frame_next;
      byte_pos  <= byte_pos_next;
      slot      <= slot_next;
      run_sum   <= run_sum_next;
      err_count <= err_count_next;
    end
  end

  // frame byte store, written at the current position
  always_ff @(posedge clk) begin
    for (int i = 1; i <= BODY_LAST; i++) begin
      if (store && byte_pos == 4'(i)) begin
        fb[i] <= in_byte;
      end
    end
  end

  `BMSRX_ASSERT(a_idle_pos_zero, in_frame || byte_pos == 4'd0, "position nonzero while idle")
  `BMSRX_ASSERT(a_pos_range, byte_pos <= LAST_POS, "byte position past checksum")
  `BMSRX_ASSERT(a_slot_range, slot <= SLOT_LIMIT, "slot number past limit")
  `BMSRX_ASSERT_NEXT(a_result_closes, res_valid, !in_frame, "frame still open after result")

endmodule

`default_nettype wire

// ===== hdl/bmsrx_out_buf.sv =====
// two-entry output register with skid slot for result items
// depends on bmsrx_pkg and the assertion macro header
`default_nettype none
`include "bms_response_frame_receiver_core_defines.svh"

module bmsrx_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire bmsrx_pkg::result_t in_data,
  output logic                  in_space,
  output logic                  out_valid,
  output bmsrx_pkg::result_t    out_data,
  input  wire logic             out_ready
);
  import bmsrx_pkg::*;

  logic    main_valid, main_valid_next;
  logic    skid_valid, skid_valid_next;
  result_t main, main_next;
  result_t skid, skid_next;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign in_space  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_next       = main;
    skid_next       = skid;
    if (skid_valid) begin
      if (pop) begin
        main_next       = skid;
        skid_valid_next = 1'b0;
      end
    end else if (in_valid) begin
      if (!main_valid || pop) begin
        main_next       = in_data;
        main_valid_next = 1'b1;
      end else begin
        skid_next       = in_data;
        skid_valid_next = 1'b1;
      end
    end else if (pop) begin
      main_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main <= main_next;
    skid <= skid_next;
  end

  `BMSRX_ASSERT(a_skid_behind_main, !skid_valid || main_valid, "skid holds data with main empty")
  `BMSRX_ASSERT(a_no_write_when_full, !(skid_valid && in_valid), "result arrived with no space")
  `BMSRX_ASSERT_NEXT(a_empty_fills_main, in_valid && !main_valid,
                     main_valid && !skid_valid, "result into empty buffer went astray")

endmodule

`default_nettype wire

// ===== hdl/bms_response_frame_receiver_core.sv =====
// Response frame receiver with additive checksum.
// s_axis carries one transaction per received byte (tdata) or, with tuser set,
// a restart that clears position, slot number and running sum before a new
// response; the error count survives restarts. While idle the receiver hunts
// for the sync byte, then collects a 13-byte frame into the current slot.
// The checksum byte closes the frame and one m_axis transaction reports the
// slot, a status (tuser) and the frame fields; a byte after a sync byte seen
// with all slots used reports an overrun instead.
// A byte is taken every cycle: s_axis_tready stays high while the two-entry
// output buffer has its skid entry free, so one stalled result does not stop
// input. Each result is registered in the output buffer before it shows on
// m_axis. If m_axis stalls with two results held, s_axis_tready drops until
// one is taken.
// cfg writes the sync byte (reset 0xA5) and are always accepted.
// rst is synchronous: frame state and error count clear, buffer empties.
// includes: bmsrx_pkg, bmsrx_assembler, bmsrx_out_buf
`default_nettype none

module bms_response_frame_receiver_core #(
  parameter int FRAME_SLOTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data,      // sync_byte
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // rx_byte
  input  wire logic [0:0]   s_axis_tuser,  // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // frame_slot, responder_address, command_echo, length_byte, payload,
  // error_total, two zero bits
  output logic [bmsrx_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]        m_axis_tuser   // status
);
  import bmsrx_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  bmsrx_assembler #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_assembler (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .in_accept (in_accept),
    .in_action (s_axis_tuser[0]),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  bmsrx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_space  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out_res.error_total, out_res.payload, out_res.length_byte,
                         out_res.command_echo, out_res.responder_address,
                         out_res.frame_slot};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

// ===== tb/sv/tb_bms_response_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for bms_response_frame_receiver_core: byte stream in, frame reports out
// depends on bmsrx_pkg and the receiver rtl; expected reports come from a frame predictor below

module tb_bms_response_frame_receiver_core;
  import bmsrx_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_PCT = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS = 250;
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum int {
    FR_GOOD, FR_ADDR_HIGH, FR_ADDR_LOW, FR_SUM_BAD, FR_SUM_ZERO
  } frame_kind_t;

  typedef struct packed {
    logic        act;
    logic [7:0]  b;
    logic        chk;
    logic [5:0]  slot;
    status_t     st;
    logic [15:0] errs;
  } dir_row_t;

  // good frame, then a frame with a high address and the sync byte as command
  localparam dir_row_t DIR_ROWS [28] = '{
    '{ACT_RESTART, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hA5, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h01, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hFF, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hFF, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h80, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h01, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h7F, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hFE, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h55, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hAA, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hA1, 1'b1, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hA5, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hFF, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hA5, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'hFF, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b0, 6'd0, STATUS_OK, 16'd0},
    '{ACT_BYTE, 8'h00, 1'b1, 6'd1, STATUS_ADDR_HIGH, 16'd1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // rx_byte
  logic [0:0] s_axis_tuser = 1'b0;    // action
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // frame_slot, responder_address, command_echo, length_byte, payload, error_total, pad
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;           // status

  bms_response_frame_receiver_core #(
    .FRAME_SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // frame predictor state
  logic [7:0] rx_sync = SYNC_RESET;
  logic rx_in_frame = 1'b0;
  int rx_pos = 0;
  int rx_slot = 0;
  logic [7:0] rx_sum = 8'h00;
  logic [7:0] rx_bytes [12];
  logic [15:0] rx_errors = 16'd0;
  result_t expected_frames [$];

  int mismatches = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;

  function automatic void bump_errors();
    if (rx_errors != ERR_MAX) rx_errors++;
  endfunction

  function automatic void predict_rx(input logic act, input logic [7:0] b);
    result_t r;
    r = '0;
    if (act == ACT_RESTART) begin
      rx_in_frame = 1'b0;
      rx_pos = 0;
      rx_slot = 0;
      rx_sum = 8'h00;
      return;
    end
    if (!rx_in_frame) begin
      if (b == rx_sync) begin
        rx_in_frame = 1'b1;
        rx_pos = 0;
        rx_sum = 8'h00;
        // with all slots used the frame opens but stores nothing
        if (rx_slot < SLOTS) begin
          rx_bytes[0] = b;
          rx_sum = b;
          rx_pos = 1;
        end
      end
      return;
    end
    if (rx_slot >= SLOTS) begin
      rx_in_frame = 1'b0;
      bump_errors();
      r.frame_slot = rx_slot[5:0];
      r.status = STATUS_OVERRUN;
      r.error_total = rx_errors;
      expected_frames.push_back(r);
      return;
    end
    if (rx_pos < LAST_POS) begin
      rx_bytes[rx_pos] = b;
      rx_sum = rx_sum + b;
      rx_pos++;
      return;
    end
    // checksum byte closes the frame
    if (rx_bytes[1] != GOOD_ADDRESS) begin
      if (rx_bytes[1] >= LOUD_ADDRESS) begin
        r.status = STATUS_ADDR_HIGH;
        bump_errors();
      end else begin
        r.status = STATUS_ADDR_LOW;
      end
    end else if (rx_sum != b) begin
      r.status = STATUS_SUM_BAD;
      bump_errors();
    end else if (rx_sum == 8'h00) begin
      r.status = STATUS_SUM_ZERO;
      bump_errors();
    end else begin
      r.status = STATUS_OK;
    end
    for (int i = 4; i <= BODY_LAST; i++) r.payload = {r.payload[55:0], rx_bytes[i]};
    r.frame_slot = rx_slot[5:0];
    r.responder_address = rx_bytes[1];
    r.command_echo = rx_bytes[2];
    r.length_byte = rx_bytes[3];
    r.error_total = rx_errors;
    expected_frames.push_back(r);
    rx_slot++;
    rx_in_frame = 1'b0;
    rx_pos = 0;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == rx_sync);
    return b;
  endfunction

  task automatic send_rx(input logic act, input logic [7:0] b);
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= b;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    predict_rx(act, b);
    items_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fb [13];
    logic [7:0] sum;
    int cut;
    fb[0] = rx_sync;
    for (int i = 2; i <= BODY_LAST; i++) fb[i] = 8'($urandom_range(0, 255));
    case (kind)
      FR_ADDR_HIGH: fb[1] = 8'($urandom_range(LOUD_ADDRESS, 255));
      FR_ADDR_LOW: begin
        do fb[1] = 8'($urandom_range(0, LOUD_ADDRESS - 1)); while (fb[1] == GOOD_ADDRESS);
      end
      default: fb[1] = GOOD_ADDRESS;
    endcase
    sum = 8'h00;
    for (int i = 0; i < BODY_LAST; i++) sum = sum + fb[i];
    if (kind == FR_SUM_ZERO) fb[BODY_LAST] = -sum;
    sum = sum + fb[BODY_LAST];
    case (kind)
      FR_GOOD, FR_SUM_ZERO: fb[LAST_POS] = sum;
      FR_SUM_BAD: fb[LAST_POS] = sum ^ 8'($urandom_range(1, 255));
      default: fb[LAST_POS] = 8'($urandom_range(0, 255));
    endcase
    // now and then a restart breaks the frame off
    cut = ($urandom_range(0, 99) < 5) ? $urandom_range(1, LAST_POS) : FRAME_LEN;
    for (int i = 0; i < cut; i++) send_rx(ACT_BYTE, fb[i]);
    if (cut < FRAME_LEN) send_rx(ACT_RESTART, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_response();
    int frames;
    send_rx(ACT_RESTART, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) send_rx(ACT_BYTE, pick_noise());
    // sometimes run the slots out to reach the overrun report
    frames = ($urandom_range(0, 99) < 12) ? $urandom_range(SLOTS - 1, SLOTS + 2)
                                          : $urandom_range(1, 4);
    repeat (frames) send_frame(frame_kind_t'($urandom_range(FR_GOOD, FR_SUM_ZERO)));
    if ($urandom_range(0, 99) < 30) send_rx(ACT_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    rx_sync = v;
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $error("result transaction with nothing expected, status %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_slot", 64'(want.frame_slot), 64'(m_axis_tdata[5:0]));
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("responder_address", 64'(want.responder_address),
                    64'(m_axis_tdata[13:6]));
        check_field("command_echo", 64'(want.command_echo), 64'(m_axis_tdata[21:14]));
        check_field("length_byte", 64'(want.length_byte), 64'(m_axis_tdata[29:22]));
        check_field("payload", want.payload, m_axis_tdata[93:30]);
        check_field("error_total", 64'(want.error_total), 64'(m_axis_tdata[109:94]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("bms_response_frame_receiver_core verification failed");
    $finish;
  end

  initial begin
    result_t last;
    int goal;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      send_rx(DIR_ROWS[i].act, DIR_ROWS[i].b);
      if (DIR_ROWS[i].chk) begin
        last = expected_frames[$];
        check_field("table frame_slot", 64'(DIR_ROWS[i].slot), 64'(last.frame_slot));
        check_field("table status", 64'(DIR_ROWS[i].st), 64'(last.status));
        check_field("table error_total", 64'(DIR_ROWS[i].errs), 64'(last.error_total));
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: write_sync(8'h00);
          2: write_sync(8'hFF);
          default: write_sync(8'($urandom_range(0, 255)));
        endcase
      end
      goal = items_sent + PHASE_ITEMS;
      if (phase == 2) begin
        // output held off while good frames keep coming, so the input stalls
        send_rx(ACT_RESTART, 8'($urandom_range(0, 255)));
        hold_go = 1'b1;
        repeat (6) send_frame(FR_GOOD);
      end
      while (items_sent < goal) begin
        calm = (phase == 1) && (items_sent < goal - PHASE_ITEMS / 2);
        send_response();
      end
      calm = 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("bms_response_frame_receiver_core verification clean");
    end else begin
      $display("bms_response_frame_receiver_core verification failed");
    end
    $finish;
  end

endmodule
